// File: src/sbpf_pkg.sv
package sbpf_pkg;

   localparam int POS_W        = 32;
   localparam int DIFF_W       = 33;
   localparam int SQ_W         = 65;
   localparam int SUM_W        = 66;
   localparam int RAD_W        = 31;
   localparam int R2_W         = 62;
   localparam int INV_W        = 48;
   localparam int INV_HALF     = 24;
   localparam int FORCE_W      = 48;
   localparam int DIST_W       = 34;
   localparam int SQRT_STAGES  = DIST_W;
   localparam int QUO_W        = FORCE_W - 1;
   localparam int PNUM_W       = 64;
   localparam int OKP_W        = DIST_W + INV_HALF;
   localparam int OK_W         = 84;
   localparam int OK_PIECE_W   = 28;
   localparam int FPP_W        = DIFF_W + OK_PIECE_W;
   localparam int FNUM_W       = 115;
   localparam int FIFO_DEPTH   = 4;
   localparam int PTR_W        = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 48;

   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_STEP = 3'd4;

   localparam logic [RAD_W-1:0]   RADIUS_RESET  = 31'd65536;
   localparam logic [INV_W-1:0]   INV_RESET     = 48'd65536;
   localparam logic [FORCE_W-1:0] FORCE_MAX_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [FORCE_W-1:0] FORCE_MAX_NEG = 48'h8000_0000_0000;
   localparam logic [POS_W-1:0]   POS_MAX       = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0]   POS_MIN       = 32'h8000_0000;

   typedef struct packed {
      logic signed [POS_W-1:0] center_x;
      logic signed [POS_W-1:0] center_y;
      logic signed [POS_W-1:0] center_z;
      logic [RAD_W-1:0]        radius;
      logic [INV_W-1:0]        inv_step;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_word_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic signed [FORCE_W-1:0] force_z;
      logic                      outside;
      logic signed [POS_W-1:0]   proj_x;
      logic signed [POS_W-1:0]   proj_y;
      logic signed [POS_W-1:0]   proj_z;
   } rsp_word_type;

   typedef struct packed {
      logic                         outside;
      logic [2:0][POS_W-1:0]        pos;
      logic [2:0][DIFF_W-1:0]       diff;
   } side_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      side_type         side;
   } front_word_type;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] d);
      return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
   endfunction

endpackage

// File: src/sphere_boundary_penalty_force_core.sv
// Spherical boundary penalty force.
// The req channel carries one particle position word (signed fixed point per axis); the
// rsp channel returns one word per position: penalty force per axis, an outside flag and
// the position projected onto the sphere surface (the input position when inside).
// Both channels move a word at a clock edge where valid is high and stall is low.
// The csr port writes the sphere centre, radius and stiffness; write only while idle.
// From an accepted request to a valid response a position passes 3 front stages
// (offsets, squares, sum and compare), a 4-word queue, 34 square-root stages, 6 stages of
// partial products and saturation checks, 47 restoring-divider stages and the output
// register. A new position is accepted every cycle while req_stall is low; the 47-stage
// divider pipelines set the latency.
// When rsp_stall is high while rsp_valid is high the back pipeline holds; the front keeps
// accepting until the queue is full and its last stage holds a word, then raises req_stall.
// Synchronous reset clears all valid state and loads the register reset values
// (centre 0, radius 1.0, stiffness 1.0).
module sphere_boundary_penalty_force_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sbpf_pkg::req_word_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sbpf_pkg::rsp_word_type                rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [sbpf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sbpf_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   sbpf_pkg::cfg_type        cfg_ff, cfg_in;
   logic                     fifo_full, fifo_empty, push, pop;
   sbpf_pkg::front_word_type push_data, head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sbpf_pkg::REG_CENTER_X: cfg_in.center_x = csr_wr_data[sbpf_pkg::POS_W-1:0];
            sbpf_pkg::REG_CENTER_Y: cfg_in.center_y = csr_wr_data[sbpf_pkg::POS_W-1:0];
            sbpf_pkg::REG_CENTER_Z: cfg_in.center_z = csr_wr_data[sbpf_pkg::POS_W-1:0];
            sbpf_pkg::REG_RADIUS:   cfg_in.radius   = csr_wr_data[sbpf_pkg::RAD_W-1:0];
            sbpf_pkg::REG_INV_STEP: cfg_in.inv_step = csr_wr_data[sbpf_pkg::INV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x <= '0;
         cfg_ff.center_y <= '0;
         cfg_ff.center_z <= '0;
         cfg_ff.radius   <= sbpf_pkg::RADIUS_RESET;
         cfg_ff.inv_step <= sbpf_pkg::INV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .fifo_full (fifo_full),
      .push      (push),
      .push_data (push_data)
   );

   sbpf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .empty     (fifo_empty),
      .full      (fifo_full),
      .head      (head)
   );

   sbpf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .fifo_head  (head),
      .fifo_pop   (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: src/sbpf_fifo.sv
module sbpf_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sbpf_pkg::front_word_type push_data,
   input  logic                     pop,
   output logic                     empty,
   output logic                     full,
   output sbpf_pkg::front_word_type head
);
   localparam int DEPTH = sbpf_pkg::FIFO_DEPTH;
   localparam int PTR_W = sbpf_pkg::PTR_W;

   sbpf_pkg::front_word_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (PTR_W+1)'(1);
         2'b01:   count_in = count_ff - (PTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("word pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("word popped from an empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + (PTR_W+1)'(1)))
      else $error("queue count did not follow a push");

endmodule

// File: src/sbpf_front.sv
module sbpf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  sbpf_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sbpf_pkg::req_word_type   req_data,
   input  logic                     fifo_full,
   output logic                     push,
   output sbpf_pkg::front_word_type push_data
);
   localparam int POS_W  = sbpf_pkg::POS_W;
   localparam int DIFF_W = sbpf_pkg::DIFF_W;
   localparam int SQ_W   = sbpf_pkg::SQ_W;
   localparam int SUM_W  = sbpf_pkg::SUM_W;
   localparam int R2_W   = sbpf_pkg::R2_W;

   logic [2:0] vld_ff;
   logic       adv;

   logic [2:0][POS_W-1:0]  cen;
   logic [2:0][POS_W-1:0]  pos_in, pos1_ff, pos2_ff;
   logic [2:0][DIFF_W-1:0] diff_in, diff1_ff, diff2_ff;
   logic [2:0][SQ_W-1:0]   sq_in, sq2_ff;
   logic [R2_W-1:0]        r2_in, r2_ff;
   sbpf_pkg::front_word_type word_in, word_ff;

   assign adv       = !vld_ff[2] || !fifo_full;
   assign req_stall = !adv;
   assign push      = vld_ff[2] && !fifo_full;
   assign push_data = word_ff;

   always_comb begin
      logic [DIFF_W-1:0] ad;
      cen[0] = cfg.center_x;
      cen[1] = cfg.center_y;
      cen[2] = cfg.center_z;
      pos_in[0] = req_data.pos_x;
      pos_in[1] = req_data.pos_y;
      pos_in[2] = req_data.pos_z;
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = {pos_in[i][POS_W-1], pos_in[i]} - {cen[i][POS_W-1], cen[i]};
         ad = sbpf_pkg::abs_diff(diff1_ff[i]);
         sq_in[i] = SQ_W'(ad) * SQ_W'(ad);
      end
      r2_in = R2_W'(cfg.radius) * R2_W'(cfg.radius);
      word_in.sum = SUM_W'(sq2_ff[0]) + SUM_W'(sq2_ff[1]) + SUM_W'(sq2_ff[2]);
      word_in.side.outside = (word_in.sum > SUM_W'(r2_ff));
      word_in.side.pos = pos2_ff;
      word_in.side.diff = diff2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos1_ff  <= pos_in;
         diff1_ff <= diff_in;
         pos2_ff  <= pos1_ff;
         diff2_ff <= diff1_ff;
         sq2_ff   <= sq_in;
         r2_ff    <= r2_in;
         word_ff  <= word_in;
      end
   end

endmodule

// File: src/sbpf_isqrt.sv
module sbpf_isqrt (
   input  logic                                clock,
   input  logic                                en,
   input  logic [2*sbpf_pkg::SQRT_STAGES-1:0]  radicand,
   output logic [sbpf_pkg::SQRT_STAGES-1:0]    root
);
   localparam int STAGES = sbpf_pkg::SQRT_STAGES;
   localparam int X_W    = 2 * STAGES;
   localparam int REM_W  = STAGES + 2;

   logic [X_W-1:0]    x_ff    [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [STAGES-1:0] root_ff [STAGES];

   assign root = root_ff[STAGES-1];

   // One result bit per stage, taking radicand bit pairs from the top down.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int K = STAGES - 1 - s;
      logic [X_W-1:0]    x_prev;
      logic [REM_W-1:0]  rem_prev, rem_in;
      logic [STAGES-1:0] root_prev, root_in;
      logic [REM_W+1:0]  tmp;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (s == 0) begin : g_first
         assign x_prev    = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign x_prev    = x_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      always_comb begin
         tmp     = {rem_prev, x_prev[2*K+1 -: 2]};
         trial   = {root_prev, 2'b01};
         ge      = (tmp >= (REM_W+2)'(trial));
         rem_in  = ge ? REM_W'(tmp - (REM_W+2)'(trial)) : REM_W'(tmp);
         root_in = {root_prev[STAGES-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s]    <= x_prev;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end
   end

endmodule

// File: src/sbpf_div.sv
module sbpf_div #(
   parameter int NW = 64,
   parameter int DW = 34,
   parameter int QW = 47
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   // The numerator must stay below den * 2^QW; the quotient then fits QW bits.
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [CW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   assign quo = quo_ff[QW-1];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int K = QW - 1 - s;
      logic [CW-1:0] rem_prev, rem_in, shifted;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev, quo_in;
      logic          ge;

      if (s == 0) begin : g_first
         assign rem_prev = CW'(num);
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      always_comb begin
         shifted = CW'(den_prev) << K;
         ge      = (rem_prev >= shifted);
         rem_in  = ge ? rem_prev - shifted : rem_prev;
         quo_in  = {quo_prev[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            quo_ff[s] <= quo_in;
         end
      end
   end

endmodule

// File: src/sbpf_back.sv
module sbpf_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sbpf_pkg::cfg_type        cfg,
   input  logic                     fifo_empty,
   input  sbpf_pkg::front_word_type fifo_head,
   output logic                     fifo_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sbpf_pkg::rsp_word_type   rsp_data
);
   localparam int POS_W       = sbpf_pkg::POS_W;
   localparam int DIFF_W      = sbpf_pkg::DIFF_W;
   localparam int DIST_W      = sbpf_pkg::DIST_W;
   localparam int SQRT_STAGES = sbpf_pkg::SQRT_STAGES;
   localparam int QUO_W       = sbpf_pkg::QUO_W;
   localparam int OKP_W       = sbpf_pkg::OKP_W;
   localparam int OK_W        = sbpf_pkg::OK_W;
   localparam int OK_PIECE_W  = sbpf_pkg::OK_PIECE_W;
   localparam int INV_HALF    = sbpf_pkg::INV_HALF;
   localparam int FPP_W       = sbpf_pkg::FPP_W;
   localparam int FNUM_W      = sbpf_pkg::FNUM_W;
   localparam int PNUM_W      = sbpf_pkg::PNUM_W;
   localparam int FORCE_W     = sbpf_pkg::FORCE_W;
   localparam int DEN_W       = DIST_W + FRAC_BITS;
   localparam int LAT         = SQRT_STAGES + 7 + QUO_W;

   typedef struct packed {
      sbpf_pkg::side_type side;
      logic [2:0]         sat;
   } tail_type;

   logic           en;
   logic [LAT-1:0] vld_ff;

   sbpf_pkg::side_type sq_side_ff [SQRT_STAGES];
   logic [DIST_W-1:0]  root;

   logic [DIST_W-1:0]          dist1_in, dist1_ff, over1_in, over1_ff;
   logic [2:0][DIFF_W-1:0]     ad1_in, ad1_ff;
   sbpf_pkg::side_type         s1_ff;

   logic [OKP_W-1:0]           okp_lo2_in, okp_lo2_ff, okp_hi2_in, okp_hi2_ff;
   logic [2:0][PNUM_W-1:0]     pnum2_in, pnum2_ff;
   logic [2:0][DIFF_W-1:0]     ad2_ff;
   logic [DIST_W-1:0]          dist2_ff;
   sbpf_pkg::side_type         s2_ff;

   logic [OK_W-1:0]            ok3_in, ok3_ff;
   logic [2:0][DIFF_W-1:0]     ad3_ff;
   logic [2:0][PNUM_W-1:0]     pnum3_ff;
   logic [DIST_W-1:0]          dist3_ff;
   sbpf_pkg::side_type         s3_ff;

   logic [2:0][2:0][FPP_W-1:0] fpp4_in, fpp4_ff;
   logic [2:0][PNUM_W-1:0]     pnum4_ff;
   logic [DIST_W-1:0]          dist4_ff;
   sbpf_pkg::side_type         s4_ff;

   logic [2:0][FNUM_W-1:0]     fnum5_in, fnum5_ff;
   logic [2:0][PNUM_W-1:0]     pnum5_ff;
   logic [DIST_W-1:0]          dist5_ff;
   sbpf_pkg::side_type         s5_ff;

   logic [2:0][FNUM_W-1:0]     fnum6_in, fnum6_ff;
   logic [DEN_W-1:0]           fden6_in, fden6_ff;
   logic [2:0]                 sat6_in, sat6_ff;
   logic [2:0][PNUM_W-1:0]     pnum6_ff;
   logic [DIST_W-1:0]          dist6_ff;
   sbpf_pkg::side_type         s6_ff;

   tail_type                   tail_ff [QUO_W];
   logic [2:0][QUO_W-1:0]      fq, pq;

   sbpf_pkg::rsp_word_type     rsp_in, rsp_ff;

   // The whole back pipeline freezes while the output word waits.
   assign en        = !vld_ff[LAT-1] || !rsp_stall;
   assign fifo_pop  = en && !fifo_empty;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   sbpf_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand ((2*SQRT_STAGES)'(fifo_head.sum)),
      .root     (root)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      sbpf_div #(.NW(FNUM_W), .DW(DEN_W), .QW(QUO_W)) u_fdiv (
         .clock (clock),
         .en    (en),
         .num   (fnum6_ff[i]),
         .den   (fden6_ff),
         .quo   (fq[i])
      );
      sbpf_div #(.NW(PNUM_W), .DW(DIST_W), .QW(QUO_W)) u_pdiv (
         .clock (clock),
         .en    (en),
         .num   (pnum6_ff[i]),
         .den   (dist6_ff),
         .quo   (pq[i])
      );
   end

   always_comb begin
      logic [DIST_W-1:0]         r34;
      logic [FNUM_W-1:0]         limit;
      logic [2:0][POS_W-1:0]     cen;
      logic [2:0][FORCE_W-1:0]   frc;
      logic [2:0][POS_W-1:0]     prj;
      logic [FORCE_W-1:0]        q48;
      logic [POS_W+2:0]          q35, c35, p35;
      logic                      dneg;
      tail_type                  t;

      r34 = DIST_W'(cfg.radius);
      dist1_in = root;
      over1_in = (root > r34) ? root - r34 : '0;
      for (int i = 0; i < 3; i++) begin
         ad1_in[i] = sbpf_pkg::abs_diff(sq_side_ff[SQRT_STAGES-1].diff[i]);
      end

      okp_lo2_in = OKP_W'(over1_ff) * OKP_W'(cfg.inv_step[INV_HALF-1:0]);
      okp_hi2_in = OKP_W'(over1_ff) * OKP_W'(cfg.inv_step[2*INV_HALF-1:INV_HALF]);
      for (int i = 0; i < 3; i++) begin
         pnum2_in[i] = PNUM_W'(ad1_ff[i]) * PNUM_W'(cfg.radius);
      end

      ok3_in = OK_W'(okp_lo2_ff) + (OK_W'(okp_hi2_ff) << INV_HALF);

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            fpp4_in[i][j] = FPP_W'(ad3_ff[i]) * FPP_W'(ok3_ff[j*OK_PIECE_W +: OK_PIECE_W]);
         end
         fnum5_in[i] = FNUM_W'(fpp4_ff[i][0]) + (FNUM_W'(fpp4_ff[i][1]) << OK_PIECE_W)
                     + (FNUM_W'(fpp4_ff[i][2]) << (2*OK_PIECE_W));
      end

      // A quotient of 2^47 or more saturates; the divider then gets zero.
      fden6_in = DEN_W'(dist5_ff) << FRAC_BITS;
      limit = FNUM_W'(fden6_in) << QUO_W;
      for (int i = 0; i < 3; i++) begin
         sat6_in[i]  = (fnum5_ff[i] >= limit);
         fnum6_in[i] = sat6_in[i] ? '0 : fnum5_ff[i];
      end

      t = tail_ff[QUO_W-1];
      cen[0] = cfg.center_x;
      cen[1] = cfg.center_y;
      cen[2] = cfg.center_z;
      for (int i = 0; i < 3; i++) begin
         dneg = t.side.diff[i][DIFF_W-1];
         q48 = {1'b0, fq[i]};
         if (t.sat[i]) begin
            frc[i] = dneg ? sbpf_pkg::FORCE_MAX_POS : sbpf_pkg::FORCE_MAX_NEG;
         end else begin
            frc[i] = dneg ? q48 : -q48;
         end
         q35 = (POS_W+3)'(pq[i][DIFF_W-1:0]);
         c35 = {{3{cen[i][POS_W-1]}}, cen[i]};
         p35 = dneg ? c35 - q35 : c35 + q35;
         if (p35[POS_W+2:POS_W-1] == '0 || p35[POS_W+2:POS_W-1] == '1) begin
            prj[i] = p35[POS_W-1:0];
         end else begin
            prj[i] = p35[POS_W+2] ? sbpf_pkg::POS_MIN : sbpf_pkg::POS_MAX;
         end
         if (!t.side.outside) begin
            frc[i] = '0;
            prj[i] = t.side.pos[i];
         end
      end
      rsp_in.force_x = frc[0];
      rsp_in.force_y = frc[1];
      rsp_in.force_z = frc[2];
      rsp_in.outside = t.side.outside;
      rsp_in.proj_x  = prj[0];
      rsp_in.proj_y  = prj[1];
      rsp_in.proj_z  = prj[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], !fifo_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= fifo_head.side;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
         dist1_ff   <= dist1_in;
         over1_ff   <= over1_in;
         ad1_ff     <= ad1_in;
         s1_ff      <= sq_side_ff[SQRT_STAGES-1];
         okp_lo2_ff <= okp_lo2_in;
         okp_hi2_ff <= okp_hi2_in;
         pnum2_ff   <= pnum2_in;
         ad2_ff     <= ad1_ff;
         dist2_ff   <= dist1_ff;
         s2_ff      <= s1_ff;
         ok3_ff     <= ok3_in;
         ad3_ff     <= ad2_ff;
         pnum3_ff   <= pnum2_ff;
         dist3_ff   <= dist2_ff;
         s3_ff      <= s2_ff;
         fpp4_ff    <= fpp4_in;
         pnum4_ff   <= pnum3_ff;
         dist4_ff   <= dist3_ff;
         s4_ff      <= s3_ff;
         fnum5_ff   <= fnum5_in;
         pnum5_ff   <= pnum4_ff;
         dist5_ff   <= dist4_ff;
         s5_ff      <= s4_ff;
         fnum6_ff   <= fnum6_in;
         fden6_ff   <= fden6_in;
         sat6_ff    <= sat6_in;
         pnum6_ff   <= pnum5_ff;
         dist6_ff   <= dist5_ff;
         s6_ff      <= s5_ff;
         tail_ff[0] <= {s6_ff, sat6_ff};
         for (int k = 1; k < QUO_W; k++) begin
            tail_ff[k] <= tail_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   a_pop_enters: assert property (@(posedge clock) disable iff (reset) fifo_pop |=> vld_ff[0])
      else $error("popped word did not enter the back pipeline");
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.outside) |->
      (rsp_data.force_x == '0 && rsp_data.force_y == '0 && rsp_data.force_z == '0))
      else $error("nonzero force for a position inside the sphere");
   a_outside_dist: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[SQRT_STAGES] && s1_ff.outside) |-> (dist1_ff >= DIST_W'(cfg.radius)))
      else $error("distance below radius for a position outside the sphere");

endmodule
